[src/lpc_poly_to_reflection_defines.svh]
// ----------------------------------------------------------------------------
// lpc_poly_to_reflection assertion macros
// Shared concurrent assertion forms for the block's checker.
// ----------------------------------------------------------------------------
`ifndef LPC_POLY_TO_REFLECTION_DEFINES_SVH
`define LPC_POLY_TO_REFLECTION_DEFINES_SVH

// same-cycle implication
`define LPCR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lpc_poly_to_reflection check failed");

// next-cycle implication
`define LPCR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lpc_poly_to_reflection check failed");

`endif

[src/lpcr_pkg.sv]
// ----------------------------------------------------------------------------
// lpcr_pkg
// Constants, types and fixed-point helpers for the step-down converter.
// ----------------------------------------------------------------------------
package lpcr_pkg;

   localparam int MAX_ORDER = 32;
   localparam int IDX_W     = $clog2(MAX_ORDER);
   localparam int CNT_W     = $clog2(MAX_ORDER + 2);
   localparam int COEF_W    = 16;
   localparam int WORK_W    = 32;
   localparam int WORK_FRAC = WORK_W - 6;
   localparam int DVD_W     = WORK_W + WORK_FRAC;
   localparam int DCNT_W    = $clog2(DVD_W + 1);
   localparam int SAT_W     = DVD_W + 1;
   localparam int OUT_W     = 16;
   localparam int OUT_FRAC  = 15;
   localparam int OUT_SH    = WORK_FRAC - OUT_FRAC;

   localparam logic [WORK_W-1:0] W_ONE = WORK_W'(1) << WORK_FRAC;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_ZERO_LEAD  = 3'd1,
      ST_UNSTABLE   = 3'd2,
      ST_TOO_LONG   = 3'd3,
      ST_ORDER_ZERO = 3'd4
   } status_type;

   typedef struct packed {
      logic                     bank;
      logic [CNT_W-1:0]         order;
      logic signed [COEF_W-1:0] lead;
      status_type               cls;
   } job_type;

   function automatic logic [WORK_W-1:0] mag(input logic [WORK_W-1:0] v);
      return v[WORK_W-1] ? (~v + WORK_W'(1)) : v;
   endfunction

   function automatic logic [WORK_W-1:0] sat_mag(input logic [SAT_W-1:0] m, input logic neg);
      logic [SAT_W-1:0]  lim;
      logic [WORK_W-1:0] r;
      lim = (SAT_W'(1) << (WORK_W - 1)) - SAT_W'(!neg);
      r   = m[WORK_W-1:0];
      if (m > lim)
         return neg ? {1'b1, {(WORK_W-1){1'b0}}} : {1'b0, {(WORK_W-1){1'b1}}};
      return neg ? (~r + WORK_W'(1)) : r;
   endfunction

   function automatic logic [WORK_W-1:0] round_mul(input logic [2*WORK_W-1:0] p,
                                                   input logic neg);
      logic [2*WORK_W:0] t;
      t = {1'b0, p} + ((2*WORK_W+1)'(1) << (WORK_FRAC - 1));
      t = t >> WORK_FRAC;
      return sat_mag(t[SAT_W-1:0], neg);
   endfunction

   function automatic logic [OUT_W-1:0] to_q15(input logic [WORK_W-1:0] k);
      logic [WORK_W:0] s;
      s = ({1'b0, mag(k)} + ((WORK_W+1)'(1) << (OUT_SH - 1))) >> OUT_SH;
      if (k[WORK_W-1]) begin
         if (s > (WORK_W+1)'(32768))
            return 16'h8000;
         return ~s[OUT_W-1:0] + 16'd1;
      end
      if (s > (WORK_W+1)'(32767))
         return 16'h7fff;
      return s[OUT_W-1:0];
   endfunction

endpackage

[src/lpc_poly_to_reflection.sv]
// ----------------------------------------------------------------------------
// lpc_poly_to_reflection
// Prediction polynomial to reflection coefficients by Levinson step-down.
// ----------------------------------------------------------------------------
// Request side: push a Q4.12 coefficient on req_coef, leading one first, and
// raise req_last_coef on the final one; a request is taken when req_push is
// high and req_full is low. Up to two polynomials are held at once: the next
// one is taken while the previous one is computed and drained.
// Result side: while rsp_empty is low, rsp_refl (Q1.15), rsp_last_refl and
// rsp_status show the oldest result; rsp_pop takes it. k1..kP come in order.
// After the last coefficient, order P, the block first normalizes each
// coefficient by a division, then runs P*(P-1)/2 coefficient updates, one
// division each, over the step-down stages, then streams out the results. The
// serial divider (58 quotient bits, one a cycle) paces normalization and each
// update. Error cases skip normalization and step-down and go to their results.
// Reset clears all control state and any queued polynomial. A stalled result
// side holds the current result; the step-down sequencer then waits, and
// req_full rises once two polynomials are pending.
// ----------------------------------------------------------------------------
module lpc_poly_to_reflection (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   input  logic signed [lpcr_pkg::COEF_W-1:0] req_coef,
   input  logic                               req_last_coef,
   output logic                               req_full,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic signed [lpcr_pkg::OUT_W-1:0]  rsp_refl,
   output logic                               rsp_last_refl,
   output logic [2:0]                         rsp_status
);

   logic                               job_full, job_push, job_valid, job_pop;
   lpcr_pkg::job_type                  job_in, job_out;
   logic [lpcr_pkg::IDX_W:0]           raw_addr;
   logic signed [lpcr_pkg::COEF_W-1:0] raw_data;

   lpcr_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_coef      (req_coef),
      .req_last_coef (req_last_coef),
      .req_full      (req_full),
      .job_full      (job_full),
      .job_push      (job_push),
      .job_data      (job_in),
      .raw_addr      (raw_addr),
      .raw_data      (raw_data)
   );

   lpcr_job_fifo u_jobq (
      .clock (clock),
      .reset (reset),
      .push  (job_push),
      .din   (job_in),
      .full  (job_full),
      .pop   (job_pop),
      .valid (job_valid),
      .dout  (job_out)
   );

   lpcr_back u_back (
      .clock         (clock),
      .reset         (reset),
      .job_valid     (job_valid),
      .job           (job_out),
      .job_pop       (job_pop),
      .raw_addr      (raw_addr),
      .raw_data      (raw_data),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_refl      (rsp_refl),
      .rsp_last_refl (rsp_last_refl),
      .rsp_status    (rsp_status)
   );

endmodule

[src/lpcr_front.sv]
// ----------------------------------------------------------------------------
// lpcr_front
// Accepts coefficients, stores them in a two-bank store and classifies each
// polynomial into a job when its last coefficient arrives.
// ----------------------------------------------------------------------------
module lpcr_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   input  logic signed [lpcr_pkg::COEF_W-1:0] req_coef,
   input  logic                             req_last_coef,
   output logic                             req_full,
   input  logic                             job_full,
   output logic                             job_push,
   output lpcr_pkg::job_type                job_data,
   input  logic [lpcr_pkg::IDX_W:0]         raw_addr,
   output logic signed [lpcr_pkg::COEF_W-1:0] raw_data
);

   logic [lpcr_pkg::CNT_W-1:0]         cnt_ff, cnt_in, cnt_m1;
   logic                               ovf_ff, ovf_in;
   logic signed [lpcr_pkg::COEF_W-1:0] lead_ff, lead_in;
   logic                               bank_ff, bank_in;
   logic                               accept, mem_we;
   logic [lpcr_pkg::IDX_W:0]           mem_wa;
   logic signed [lpcr_pkg::COEF_W-1:0] raw_mem [2*lpcr_pkg::MAX_ORDER];
   logic signed [lpcr_pkg::COEF_W-1:0] raw_rd_ff;

   assign req_full = job_full;
   assign accept   = req_push && !job_full;
   assign cnt_m1   = cnt_ff - lpcr_pkg::CNT_W'(1);
   assign mem_wa   = {bank_ff, cnt_m1[lpcr_pkg::IDX_W-1:0]};
   assign raw_data = raw_rd_ff;

   always_comb begin
      cnt_in   = cnt_ff;
      ovf_in   = ovf_ff;
      lead_in  = lead_ff;
      bank_in  = bank_ff;
      mem_we   = 1'b0;
      job_push = 1'b0;
      job_data = '0;
      if (accept) begin
         if (cnt_ff == '0) begin
            lead_in = req_coef;
            cnt_in  = lpcr_pkg::CNT_W'(1);
         end else if (cnt_ff <= lpcr_pkg::CNT_W'(lpcr_pkg::MAX_ORDER)) begin
            mem_we = 1'b1;
            cnt_in = cnt_ff + lpcr_pkg::CNT_W'(1);
         end else begin
            ovf_in = 1'b1;
         end
         if (req_last_coef) begin
            job_push       = 1'b1;
            job_data.bank  = bank_ff;
            job_data.order = cnt_in - lpcr_pkg::CNT_W'(1);
            job_data.lead  = lead_in;
            if (ovf_in)
               job_data.cls = lpcr_pkg::ST_TOO_LONG;
            else if (cnt_in == lpcr_pkg::CNT_W'(1))
               job_data.cls = lpcr_pkg::ST_ORDER_ZERO;
            else if (lead_in == '0)
               job_data.cls = lpcr_pkg::ST_ZERO_LEAD;
            else
               job_data.cls = lpcr_pkg::ST_OK;
            cnt_in  = '0;
            ovf_in  = 1'b0;
            lead_in = '0;
            bank_in = ~bank_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         ovf_ff  <= 1'b0;
         lead_ff <= '0;
         bank_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         ovf_ff  <= ovf_in;
         lead_ff <= lead_in;
         bank_ff <= bank_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we)
         raw_mem[mem_wa] <= req_coef;
      raw_rd_ff <= raw_mem[raw_addr];
   end

endmodule

[src/lpcr_job_fifo.sv]
// ----------------------------------------------------------------------------
// lpcr_job_fifo
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
module lpcr_job_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  lpcr_pkg::job_type din,
   output logic              full,
   input  logic              pop,
   output logic              valid,
   output lpcr_pkg::job_type dout
);

   lpcr_pkg::job_type ent_ff [2];
   logic              wp_ff, rp_ff;
   logic [1:0]        cnt_ff;

   assign full  = (cnt_ff == 2'd2);
   assign valid = (cnt_ff != 2'd0);
   assign dout  = ent_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push)
            wp_ff <= ~wp_ff;
         if (pop)
            rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push)
         ent_ff[wp_ff] <= din;
   end

endmodule

[src/lpcr_div.sv]
// ----------------------------------------------------------------------------
// lpcr_div
// Restoring divider, one quotient bit per cycle, rounded and saturated to
// the working format.
// ----------------------------------------------------------------------------
module lpcr_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [lpcr_pkg::WORK_W-1:0] num,
   input  logic [lpcr_pkg::WORK_W-1:0] den,
   output logic                        done,
   output logic [lpcr_pkg::WORK_W-1:0] quo
);

   logic                        busy_ff, fin_ff, neg_ff;
   logic [lpcr_pkg::DCNT_W-1:0] cnt_ff;
   logic [lpcr_pkg::DVD_W-1:0]  dvd_ff, quo_ff;
   logic [lpcr_pkg::WORK_W:0]   rem_ff, rs;
   logic [lpcr_pkg::WORK_W-1:0] dm_ff;
   logic                        ge, rnd;
   logic [lpcr_pkg::SAT_W-1:0]  qr;

   assign rs   = {rem_ff[lpcr_pkg::WORK_W-1:0], dvd_ff[lpcr_pkg::DVD_W-1]};
   assign ge   = rs >= {1'b0, dm_ff};
   assign rnd  = rem_ff[lpcr_pkg::WORK_W-1:0] >= (dm_ff - rem_ff[lpcr_pkg::WORK_W-1:0]);
   assign qr   = {1'b0, quo_ff} + lpcr_pkg::SAT_W'(rnd);
   assign quo  = lpcr_pkg::sat_mag(qr, neg_ff);
   assign done = fin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         fin_ff <= busy_ff && (cnt_ff == lpcr_pkg::DCNT_W'(1));
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= lpcr_pkg::DCNT_W'(lpcr_pkg::DVD_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - lpcr_pkg::DCNT_W'(1);
            if (cnt_ff == lpcr_pkg::DCNT_W'(1))
               busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= {lpcr_pkg::mag(num), {lpcr_pkg::WORK_FRAC{1'b0}}};
         rem_ff <= '0;
         quo_ff <= '0;
         dm_ff  <= lpcr_pkg::mag(den);
         neg_ff <= num[lpcr_pkg::WORK_W-1] ^ den[lpcr_pkg::WORK_W-1];
      end else if (busy_ff) begin
         dvd_ff <= dvd_ff << 1;
         rem_ff <= ge ? (rs - {1'b0, dm_ff}) : rs;
         quo_ff <= {quo_ff[lpcr_pkg::DVD_W-2:0], ge};
      end
   end

endmodule

[src/lpcr_back.sv]
// ----------------------------------------------------------------------------
// lpcr_back
// Sequencer that normalizes, runs the step-down stages over two ping-pong
// working memories, and streams out the reflection coefficients.
// ----------------------------------------------------------------------------
module lpcr_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               job_valid,
   input  lpcr_pkg::job_type                  job,
   output logic                               job_pop,
   output logic [lpcr_pkg::IDX_W:0]           raw_addr,
   input  logic signed [lpcr_pkg::COEF_W-1:0] raw_data,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic signed [lpcr_pkg::OUT_W-1:0]  rsp_refl,
   output logic                               rsp_last_refl,
   output logic [2:0]                         rsp_status
);

   typedef enum logic [13:0] {
      BK_IDLE  = 14'b00000000000001,
      BK_N_RD  = 14'b00000000000010,
      BK_N_GO  = 14'b00000000000100,
      BK_N_WT  = 14'b00000000001000,
      BK_K_RD  = 14'b00000000010000,
      BK_K_LD  = 14'b00000000100000,
      BK_K_SQ  = 14'b00000001000000,
      BK_K_CHK = 14'b00000010000000,
      BK_S_RD  = 14'b00000100000000,
      BK_S_MUL = 14'b00001000000000,
      BK_S_SUB = 14'b00010000000000,
      BK_S_WT  = 14'b00100000000000,
      BK_E_RD  = 14'b01000000000000,
      BK_E_OUT = 14'b10000000000000
   } state_type;

   localparam int W  = lpcr_pkg::WORK_W;
   localparam int CW = lpcr_pkg::CNT_W;

   state_type            state_ff, state_in;
   logic [CW-1:0]        i_ff, i_in, p_ff, p_in, stop_ff, stop_in;
   logic [CW-1:0]        order_ff, order_in, ecnt_ff, ecnt_in;
   logic                 par_ff, par_in, bank_ff, bank_in, neg_ff, neg_in;
   lpcr_pkg::status_type cls_ff, cls_in;
   logic signed [lpcr_pkg::COEF_W-1:0] lead_ff, lead_in;
   logic [W-1:0]         k_ff, k_in, d_ff, d_in, a_ff, a_in;
   logic [2*W-1:0]       prod_ff, prod_in;

   logic                 div_start, div_done, x_we, y_we, rsp_load;
   logic [W-1:0]         div_num, div_den, div_quo;
   logic [CW-1:0]        ra, rb, rev_pos;
   logic [W-1:0]         x_mem [lpcr_pkg::MAX_ORDER];
   logic [W-1:0]         y_mem [lpcr_pkg::MAX_ORDER];
   logic [W-1:0]         x_a_ff, x_b_ff, y_a_ff, y_b_ff, src_a, src_b, e_val;
   logic [W-1:0]         rm, dk, diff_sat;
   logic [W:0]           diff;

   logic                 rsp_valid_ff;
   logic [lpcr_pkg::OUT_W-1:0] rsp_refl_ff, refl_in;
   logic                 rsp_last_ff;
   lpcr_pkg::status_type rsp_status_ff, status_in;

   lpcr_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign src_a    = par_ff ? y_a_ff : x_a_ff;
   assign src_b    = par_ff ? y_b_ff : x_b_ff;
   assign rb       = p_ff - CW'(2) - i_ff;
   assign rev_pos  = order_ff - i_ff - CW'(1);
   assign e_val    = rev_pos[0] ? y_a_ff : x_a_ff;
   assign raw_addr = {bank_ff, i_ff[lpcr_pkg::IDX_W-1:0]};
   assign rm       = lpcr_pkg::round_mul(prod_ff, neg_ff);
   assign dk       = lpcr_pkg::W_ONE - lpcr_pkg::round_mul(prod_ff, 1'b0);
   assign diff     = {a_ff[W-1], a_ff} - {rm[W-1], rm};
   assign diff_sat = (diff[W] != diff[W-1]) ?
                     (diff[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}}) :
                     diff[W-1:0];

   always_comb begin
      if (cls_ff != lpcr_pkg::ST_OK) begin
         refl_in   = '0;
         status_in = cls_ff;
      end else if ((stop_ff != '0) && ((i_ff + CW'(1)) < stop_ff)) begin
         refl_in   = '0;
         status_in = lpcr_pkg::ST_UNSTABLE;
      end else begin
         refl_in   = lpcr_pkg::to_q15(e_val);
         status_in = (lpcr_pkg::mag(e_val) >= lpcr_pkg::W_ONE) ?
                     lpcr_pkg::ST_UNSTABLE : lpcr_pkg::ST_OK;
      end
   end

   always_comb begin
      state_in  = state_ff;
      i_in      = i_ff;
      p_in      = p_ff;
      stop_in   = stop_ff;
      order_in  = order_ff;
      ecnt_in   = ecnt_ff;
      par_in    = par_ff;
      bank_in   = bank_ff;
      neg_in    = neg_ff;
      cls_in    = cls_ff;
      lead_in   = lead_ff;
      k_in      = k_ff;
      d_in      = d_ff;
      a_in      = a_ff;
      prod_in   = prod_ff;
      div_start = 1'b0;
      div_num   = diff_sat;
      div_den   = d_ff;
      x_we      = 1'b0;
      y_we      = 1'b0;
      job_pop   = 1'b0;
      rsp_load  = 1'b0;
      ra        = i_ff;
      case (state_ff)
         BK_IDLE: begin
            if (job_valid) begin
               order_in = job.order;
               cls_in   = job.cls;
               bank_in  = job.bank;
               lead_in  = job.lead;
               i_in     = '0;
               p_in     = job.order;
               stop_in  = '0;
               par_in   = 1'b0;
               case (job.cls)
                  lpcr_pkg::ST_TOO_LONG:   ecnt_in = CW'(lpcr_pkg::MAX_ORDER);
                  lpcr_pkg::ST_ORDER_ZERO: ecnt_in = CW'(1);
                  default:                 ecnt_in = job.order;
               endcase
               state_in = (job.cls == lpcr_pkg::ST_OK) ? BK_N_RD : BK_E_RD;
            end
         end
         BK_N_RD: state_in = BK_N_GO;
         BK_N_GO: begin
            div_start = 1'b1;
            div_num   = {{(W-lpcr_pkg::COEF_W){raw_data[lpcr_pkg::COEF_W-1]}}, raw_data};
            div_den   = {{(W-lpcr_pkg::COEF_W){lead_ff[lpcr_pkg::COEF_W-1]}}, lead_ff};
            state_in  = BK_N_WT;
         end
         BK_N_WT: begin
            if (div_done) begin
               x_we = 1'b1;
               if (i_ff == order_ff - CW'(1)) begin
                  i_in     = '0;
                  state_in = BK_K_RD;
               end else begin
                  i_in     = i_ff + CW'(1);
                  state_in = BK_N_RD;
               end
            end
         end
         BK_K_RD: begin
            ra = p_ff - CW'(1);
            if (p_ff == CW'(1)) begin
               i_in     = '0;
               state_in = BK_E_RD;
            end else begin
               state_in = BK_K_LD;
            end
         end
         BK_K_LD: begin
            k_in     = src_a;
            state_in = BK_K_SQ;
         end
         BK_K_SQ: begin
            if (lpcr_pkg::mag(k_ff) >= lpcr_pkg::W_ONE) begin
               stop_in  = p_ff;
               i_in     = '0;
               state_in = BK_E_RD;
            end else begin
               prod_in  = (2*W)'(lpcr_pkg::mag(k_ff)) * (2*W)'(lpcr_pkg::mag(k_ff));
               neg_in   = 1'b0;
               state_in = BK_K_CHK;
            end
         end
         BK_K_CHK: begin
            i_in = '0;
            if (dk[W-1] || (dk == '0)) begin
               stop_in  = p_ff;
               state_in = BK_E_RD;
            end else begin
               d_in     = dk;
               state_in = BK_S_RD;
            end
         end
         BK_S_RD: state_in = BK_S_MUL;
         BK_S_MUL: begin
            a_in     = src_a;
            prod_in  = (2*W)'(lpcr_pkg::mag(k_ff)) * (2*W)'(lpcr_pkg::mag(src_b));
            neg_in   = k_ff[W-1] ^ src_b[W-1];
            state_in = BK_S_SUB;
         end
         BK_S_SUB: begin
            div_start = 1'b1;
            state_in  = BK_S_WT;
         end
         BK_S_WT: begin
            if (div_done) begin
               x_we = par_ff;
               y_we = !par_ff;
               if (i_ff == p_ff - CW'(2)) begin
                  p_in     = p_ff - CW'(1);
                  par_in   = !par_ff;
                  state_in = BK_K_RD;
               end else begin
                  i_in     = i_ff + CW'(1);
                  state_in = BK_S_RD;
               end
            end
         end
         BK_E_RD: state_in = BK_E_OUT;
         BK_E_OUT: begin
            if (!rsp_valid_ff || rsp_pop) begin
               rsp_load = 1'b1;
               if (i_ff == ecnt_ff - CW'(1)) begin
                  job_pop  = 1'b1;
                  state_in = BK_IDLE;
               end else begin
                  i_in     = i_ff + CW'(1);
                  state_in = BK_E_RD;
               end
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         i_ff         <= '0;
         p_ff         <= '0;
         stop_ff      <= '0;
         order_ff     <= '0;
         ecnt_ff      <= '0;
         par_ff       <= 1'b0;
         bank_ff      <= 1'b0;
         cls_ff       <= lpcr_pkg::ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         p_ff     <= p_in;
         stop_ff  <= stop_in;
         order_ff <= order_in;
         ecnt_ff  <= ecnt_in;
         par_ff   <= par_in;
         bank_ff  <= bank_in;
         cls_ff   <= cls_in;
         if (rsp_load)
            rsp_valid_ff <= 1'b1;
         else if (rsp_pop)
            rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      lead_ff <= lead_in;
      k_ff    <= k_in;
      d_ff    <= d_in;
      a_ff    <= a_in;
      prod_ff <= prod_in;
      neg_ff  <= neg_in;
      if (rsp_load) begin
         rsp_refl_ff   <= refl_in;
         rsp_last_ff   <= (i_ff == ecnt_ff - CW'(1));
         rsp_status_ff <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (x_we)
         x_mem[i_ff[lpcr_pkg::IDX_W-1:0]] <= div_quo;
      if (y_we)
         y_mem[i_ff[lpcr_pkg::IDX_W-1:0]] <= div_quo;
      x_a_ff <= x_mem[ra[lpcr_pkg::IDX_W-1:0]];
      x_b_ff <= x_mem[rb[lpcr_pkg::IDX_W-1:0]];
      y_a_ff <= y_mem[ra[lpcr_pkg::IDX_W-1:0]];
      y_b_ff <= y_mem[rb[lpcr_pkg::IDX_W-1:0]];
   end

   assign rsp_empty     = !rsp_valid_ff;
   assign rsp_refl      = rsp_refl_ff;
   assign rsp_last_refl = rsp_last_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

[src/lpcr_checker.sv]
// ----------------------------------------------------------------------------
// lpcr_checker
// Port-level checks on the result channel of lpc_poly_to_reflection.
// ----------------------------------------------------------------------------
`include "lpc_poly_to_reflection_defines.svh"

module lpcr_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_empty,
   input logic                               rsp_pop,
   input logic signed [lpcr_pkg::OUT_W-1:0]  rsp_refl,
   input logic                               rsp_last_refl,
   input logic [2:0]                         rsp_status
);

   `LPCR_ASSERT_NEXT(a_rsp_hold, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_refl) && $stable(rsp_status) && $stable(rsp_last_refl))
   `LPCR_ASSERT_NOW(a_status_code, clock, reset, !rsp_empty, rsp_status == lpcr_pkg::ST_OK || rsp_status == lpcr_pkg::ST_ZERO_LEAD || rsp_status == lpcr_pkg::ST_UNSTABLE || rsp_status == lpcr_pkg::ST_TOO_LONG || rsp_status == lpcr_pkg::ST_ORDER_ZERO)
   `LPCR_ASSERT_NOW(a_error_zero, clock, reset, !rsp_empty && (rsp_status == lpcr_pkg::ST_ZERO_LEAD || rsp_status == lpcr_pkg::ST_TOO_LONG || rsp_status == lpcr_pkg::ST_ORDER_ZERO), rsp_refl == '0)
   `LPCR_ASSERT_NOW(a_order_zero_last, clock, reset, !rsp_empty && rsp_status == lpcr_pkg::ST_ORDER_ZERO, rsp_last_refl)

endmodule

bind lpc_poly_to_reflection lpcr_checker u_checker (.*);
